// File: hw/rtl/cpi_pkg.sv
`timescale 1ns / 1ps

package cpi_pkg;

  localparam int PAL_SIZE  = 256;
  localparam int MAX_DIM   = 4096;

  localparam int IDX_W     = $clog2(PAL_SIZE);
  localparam int ROW_W     = $clog2(MAX_DIM + 1);
  localparam int COL_W     = $clog2(MAX_DIM);

  // fixed field widths of the ports
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 3 * CHAN_W;
  localparam int OUT_IDX_W = 8;
  localparam int POS_OUT_W = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COL_W-1:0]   col_t;

  // position and shape check of one pixel
  typedef struct packed {
    row_t row;
    col_t col;
    logic shape_err;
  } pos_t;

  // pixel travelling down the palette cells
  typedef struct packed {
    logic   valid;
    color_t color;
    logic   last;
    logic   found;
    logic   is_new;
    idx_t   idx;
    pos_t   pos;
  } tok_t;

  // register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
  function automatic row_t clamp_dim(input logic [CFG_W-1:0] v);
    int unsigned wide;
    wide = 32'(v);
    if (wide == 0) begin
      return row_t'(1);
    end
    if (wide > MAX_DIM) begin
      return row_t'(MAX_DIM);
    end
    return row_t'(wide);
  endfunction

endpackage

// File: hw/rtl/cpi_ifs.sv
`timescale 1ns / 1ps

interface cpi_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface cpi_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  color_index;
  logic [11:0] pixel_row;
  logic [11:0] pixel_col;
  logic        is_new_color;
  logic        palette_full;
  logic        shape_error;

  modport source (output valid, color_index, pixel_row, pixel_col, is_new_color,
                  palette_full, shape_error, input ready);
  modport sink   (input valid, color_index, pixel_row, pixel_col, is_new_color,
                  palette_full, shape_error, output ready);
endinterface

// File: hw/rtl/cpi_pos.sv
`timescale 1ns / 1ps

module cpi_pos (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpi_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          accept,
  input  logic                          last,
  output cpi_pkg::pos_t                 pos
);
  import cpi_pkg::*;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  row_t             next_row;
  col_t             next_col;
  row_t             w;
  row_t             h;
  row_t             col_ext;
  logic             at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    w       = clamp_dim(image_width);
    h       = clamp_dim(image_height);
    col_ext = row_t'(next_col);
    at_end  = (next_row == h - row_t'(1)) && (col_ext == w - row_t'(1));
    pos.row = next_row;
    pos.col = next_col;
    pos.shape_err = (next_row >= h) || (last && !at_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_row <= '0;
      next_col <= '0;
    end else if (accept) begin
      if (last) begin
        next_row <= '0;
        next_col <= '0;
      end else if ((col_ext + row_t'(1)) >= w) begin
        next_col <= '0;
        if (next_row < h) begin
          next_row <= next_row + row_t'(1);
        end
      end else begin
        next_col <= next_col + col_t'(1);
      end
    end
  end

endmodule

// File: hw/rtl/cpi_cell.sv
`timescale 1ns / 1ps

module cpi_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  cpi_pkg::idx_t cell_idx,
  input  cpi_pkg::tok_t tok_in,
  output cpi_pkg::tok_t tok_out
);
  import cpi_pkg::*;

  color_t color;
  logic   in_use;
  logic   hit;
  logic   ins;
  tok_t   tok_next;

  always_comb begin
    hit      = tok_in.valid && !tok_in.found && in_use && (color == tok_in.color);
    ins      = tok_in.valid && !tok_in.found && !in_use;
    tok_next = tok_in;
    if (hit || ins) begin
      tok_next.found = 1'b1;
      tok_next.idx   = cell_idx;
    end
    if (ins) begin
      tok_next.is_new = 1'b1;
    end
  end

  // colour store, no reset
  always_ff @(posedge clk) begin
    if (advance && ins) begin
      color <= tok_in.color;
    end
  end

  // a last pixel empties every cell it passes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
    end else if (advance) begin
      if (tok_in.valid && tok_in.last) begin
        in_use <= 1'b0;
      end else if (ins) begin
        in_use <= 1'b1;
      end
    end
  end

  // only the valid bit needs a reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// File: hw/rtl/color_palette_indexer_core.sv
`timescale 1ns / 1ps
// path: a pixel passes the entry register, then one register per palette cell
// throughput: one pixel per cycle unless a result waits at the output; set by the
//   palette cell chain, each cell comparing one stored colour with a passing pixel
// reset: position, image size (1 x 1) and cell in-use bits clear at once;
//   palette colours are left as they are and are only read once written

module color_palette_indexer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpi_pkg::CFG_W-1:0]     cfg_data,
  cpi_pixel_if.sink                     pix,
  cpi_result_if.source                  res
);
  import cpi_pkg::*;

  // tok[0] carries the entry register, tok[PAL_SIZE] the output register
  tok_t tok [PAL_SIZE+1];
  tok_t entry;
  pos_t pos;
  logic accept;
  logic advance;

  // the whole chain moves unless a result waits at the output
  assign advance   = !(tok[PAL_SIZE].valid && !res.ready);
  assign pix.ready = advance;
  assign accept    = pix.valid && advance;

  // row, column and shape check are settled on entry, in pixel order
  cpi_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .last      (pix.last_pixel),
    .pos       (pos)
  );

  // entry register, only its valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (advance) begin
      entry.valid  <= pix.valid;
      entry.color  <= {pix.red, pix.green, pix.blue};
      entry.last   <= pix.last_pixel;
      entry.found  <= 1'b0;
      entry.is_new <= 1'b0;
      entry.idx    <= '0;
      entry.pos    <= pos;
    end
  end

  assign tok[0] = entry;

  // palette cells: a pixel takes the first matching cell, or claims the
  // first empty one; later pixels trail one cell behind so they see the insert
  for (genvar g = 0; g < PAL_SIZE; g++) begin : g_cell
    cpi_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cell_idx (idx_t'(g)),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

  // a pixel that leaves the chain unmatched found the palette full
  assign res.valid        = tok[PAL_SIZE].valid;
  assign res.color_index  = tok[PAL_SIZE].found ? OUT_IDX_W'(tok[PAL_SIZE].idx)
                                                : OUT_IDX_W'(0);
  assign res.pixel_row    = POS_OUT_W'(tok[PAL_SIZE].pos.row);
  assign res.pixel_col    = POS_OUT_W'(tok[PAL_SIZE].pos.col);
  assign res.is_new_color = tok[PAL_SIZE].is_new;
  assign res.palette_full = !tok[PAL_SIZE].found;
  assign res.shape_error  = tok[PAL_SIZE].pos.shape_err;

endmodule

// File: tb/cpi_result_checker.sv
`timescale 1ns / 1ps

module cpi_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpi_pkg::CFG_W-1:0]     cfg_data,
  cpi_pixel_if                          pix,
  cpi_result_if                         res,
  output int unsigned                   errors,
  output int unsigned                   pending,
  output int unsigned                   checked,
  output int unsigned                   full_hits,
  output int unsigned                   shape_hits
);
  import cpi_pkg::*;

  typedef struct packed {
    logic [7:0]  color_index;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic        is_new_color;
    logic        palette_full;
    logic        shape_error;
  } pixel_result_t;

  color_t           palette_mem [PAL_SIZE];
  int unsigned      palette_count;
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [CFG_W-1:0] width_val;
  logic [CFG_W-1:0] height_val;
  pixel_result_t    expected_q [$];
  int unsigned      err_count   = 0;
  int unsigned      check_count = 0;
  int unsigned      full_count  = 0;
  int unsigned      shape_count = 0;

  // 0 behaves as 1, anything past the largest size behaves as that size
  function automatic int unsigned dim_in_force(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > MAX_DIM) begin
      return MAX_DIM;
    end
    return 32'(v);
  endfunction

  function automatic pixel_result_t index_pixel(input color_t colour, input logic last);
    int unsigned   w;
    int unsigned   h;
    int unsigned   slot;
    int unsigned   i;
    logic          hit;
    pixel_result_t r;
    w    = dim_in_force(width_val);
    h    = dim_in_force(height_val);
    r    = '0;
    hit  = 1'b0;
    slot = 0;
    for (i = 0; i < palette_count && !hit; i++) begin
      if (palette_mem[i] == colour) begin
        hit  = 1'b1;
        slot = i;
      end
    end
    if (!hit) begin
      if (palette_count < PAL_SIZE) begin
        slot                       = palette_count;
        palette_mem[palette_count] = colour;
        palette_count++;
        r.is_new_color             = 1'b1;
      end else begin
        r.palette_full = 1'b1;
      end
    end
    r.color_index = 8'(slot);
    r.pixel_row   = 12'(row_pos);
    r.pixel_col   = 12'(col_pos);
    r.shape_error = (row_pos >= h) || (last && !(row_pos == h - 1 && col_pos == w - 1));
    // advance the raster position; the row sticks one past the last row
    if (last) begin
      palette_count = 0;
      row_pos       = 0;
      col_pos       = 0;
    end else if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos < h) begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      palette_count = 0;
      row_pos       = 0;
      col_pos       = 0;
      width_val     = CFG_W'(1);
      height_val    = CFG_W'(1);
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) begin
          width_val = cfg_data;
        end else if (cfg_index == REG_HEIGHT) begin
          height_val = cfg_data;
        end
      end
      if (pix.valid && pix.ready) begin
        expected_q.push_back(index_pixel({pix.red, pix.green, pix.blue}, pix.last_pixel));
      end
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no pixel outstanding");
          err_count++;
        end else begin
          want = expected_q.pop_front();
          check_count++;
          if (want.palette_full) begin
            full_count++;
          end
          if (want.shape_error) begin
            shape_count++;
          end
          check_field("color_index", 32'(want.color_index), 32'(res.color_index));
          check_field("pixel_row", 32'(want.pixel_row), 32'(res.pixel_row));
          check_field("pixel_col", 32'(want.pixel_col), 32'(res.pixel_col));
          check_field("is_new_color", 32'(want.is_new_color), 32'(res.is_new_color));
          check_field("palette_full", 32'(want.palette_full), 32'(res.palette_full));
          check_field("shape_error", 32'(want.shape_error), 32'(res.shape_error));
        end
      end
    end
    errors     <= err_count;
    pending    <= expected_q.size();
    checked    <= check_count;
    full_hits  <= full_count;
    shape_hits <= shape_count;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cpi_pkg::*;

  // quiet cycles tolerated: pipeline depth plus worst sink stall plus worst source gap,
  // taken many times over
  localparam int unsigned STALL_LIMIT = 4000;
  // cycles to linger once nothing is outstanding, a little over the pipeline depth
  localparam int unsigned DRAIN       = 300;
  localparam int unsigned RANDOM_PIXELS = 650;

  typedef enum logic [1:0] {PICK_POOL, PICK_FRESH, PICK_MIXED} colour_pick_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_BLOCKS} sink_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cpi_pixel_if  pix_if ();
  cpi_result_if res_if ();

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_hits;
  int unsigned shape_hits;

  // source-side bookkeeping
  int unsigned burst_left = 0;
  int unsigned pixels_sent = 0;
  int unsigned random_sent = 0;
  color_t      colour_pool [16];
  int unsigned pool_n = 1;
  color_t      seen_q [$];

  // sink-side pattern
  sink_mode_t  sink_mode = SINK_OPEN;
  int unsigned mode_left = 0;
  logic [7:0]  sink_tick = '0;

  int unsigned quiet_cycles = 0;

  color_palette_indexer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_if),
    .res       (res_if)
  );

  // predicts every result from the pixel transactions and compares on the result side
  cpi_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix        (pix_if),
    .res        (res_if),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .full_hits  (full_hits),
    .shape_hits (shape_hits)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sink: switches between always ready, coin toss, one in four and long blocks
  // of stall, each held for a random stretch of cycles
  always @(posedge clk) begin
    if (mode_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    sink_tick <= sink_tick + 8'd1;
    case (sink_mode)
      SINK_OPEN:    res_if.ready <= 1'b1;
      SINK_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
      SINK_QUARTER: res_if.ready <= (sink_tick[1:0] == 2'd0);
      default:      res_if.ready <= (sink_tick[4:0] >= 5'd24);
    endcase
  end

  // watchdog: any transaction or register write counts as progress
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[color_palette_indexer_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // both size registers, back to back; only called while the block is idle
  task automatic write_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one pixel transaction; bursts of random length separated by random gaps
  task automatic send_pixel(input color_t colour, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
    end
    pix_if.valid      <= 1'b1;
    pix_if.red        <= colour[23:16];
    pix_if.green      <= colour[15:8];
    pix_if.blue       <= colour[7:0];
    pix_if.last_pixel <= last;
    do @(posedge clk); while (!pix_if.ready);
    burst_left--;
    pixels_sent++;
  endtask

  function automatic color_t next_colour(input colour_pick_t how);
    case (how)
      PICK_POOL:  return colour_pool[$urandom_range(0, pool_n - 1)];
      PICK_FRESH: return color_t'($urandom);
      default: begin
        // mostly unseen colours, with the odd repeat so lookups still hit
        if (seen_q.size() != 0 && $urandom_range(0, 5) == 0) begin
          return seen_q[$urandom_range(0, seen_q.size() - 1)];
        end
        return color_t'($urandom);
      end
    endcase
  endfunction

  task automatic send_image(input int unsigned n, input logic with_last,
                            input colour_pick_t how);
    int unsigned k;
    color_t      colour;
    seen_q.delete();
    // small pool of colours so that repeats are common, extremes included
    pool_n = $urandom_range(1, 16);
    for (k = 0; k < pool_n; k++) begin
      case ($urandom_range(0, 5))
        0:       colour_pool[k] = '0;
        1:       colour_pool[k] = '1;
        default: colour_pool[k] = color_t'($urandom);
      endcase
    end
    for (k = 0; k < n; k++) begin
      colour = next_colour(how);
      seen_q.push_back(colour);
      send_pixel(colour, with_last && (k == n - 1));
    end
  endtask

  // stop offering pixels and wait for every outstanding result
  task automatic finish_phase();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mostly small sizes; sometimes zero, the largest, or beyond it
  function automatic logic [CFG_W-1:0] pick_dim();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return CFG_W'(MAX_DIM);
        2:       return CFG_W'(MAX_DIM + 1);
        3:       return '1;
        default: return CFG_W'($urandom_range(0, 8191));
      endcase
    end
    return CFG_W'($urandom_range(1, 12));
  endfunction

  initial begin
    logic [CFG_W-1:0] w_cfg;
    logic [CFG_W-1:0] h_cfg;
    int unsigned      area;
    int unsigned      n;
    int unsigned      k;
    int unsigned      kind;
    int unsigned      images;
    logic             with_last;
    colour_pick_t     how;

    pix_if.valid      <= 1'b0;
    pix_if.red        <= '0;
    pix_if.green      <= '0;
    pix_if.blue       <= '0;
    pix_if.last_pixel <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_WIDTH;
    cfg_data          <= '0;
    rst               <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // well-formed 2 x 2 image: black, white, black again, then pure red as last
    write_dims(CFG_W'(2), CFG_W'(2));
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFF0000, 1'b1);
    // last flag arriving early
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'h0000FF, 1'b1);
    finish_phase();

    // more pixels than rows: row sticks past the bottom and flags a shape error
    write_dims(CFG_W'(1), CFG_W'(2));
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'hABCDEF, 1'b0);
    send_pixel(24'h123456, 1'b1);
    finish_phase();

    // width shrinks mid-image: the column already past it wraps on the next advance
    write_dims(CFG_W'(8), CFG_W'(3));
    for (k = 0; k < 6; k++) begin
      send_pixel(color_t'($urandom), 1'b0);
    end
    finish_phase();
    write_dims(CFG_W'(3), CFG_W'(3));
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h7F7F7F, 1'b1);
    finish_phase();

    // zero sizes behave as one pixel
    write_dims('0, '0);
    send_pixel(24'h808080, 1'b1);
    finish_phase();

    // width beyond the largest size, cut short by the last flag
    write_dims('1, CFG_W'(1));
    send_pixel(24'h010203, 1'b0);
    send_pixel(24'hFEFDFC, 1'b0);
    send_pixel(24'h010203, 1'b1);
    finish_phase();

    // more distinct colours than the palette holds in one image
    write_dims(CFG_W'(20), CFG_W'(20));
    send_image(400, 1'b1, PICK_MIXED);
    finish_phase();

    // random phases: new sizes, then one to three images of mixed shapes
    while (random_sent < RANDOM_PIXELS) begin
      w_cfg = pick_dim();
      h_cfg = pick_dim();
      write_dims(w_cfg, h_cfg);
      images = $urandom_range(1, 3);
      for (k = 0; k < images; k++) begin
        area      = clamp_dim(w_cfg) * clamp_dim(h_cfg);
        kind      = $urandom_range(0, 9);
        with_last = 1'b1;
        if (kind < 6) begin
          n = area;
        end else if (kind < 8) begin
          n = (area > 1) ? $urandom_range(1, area - 1) : 1;
        end else if (kind < 9) begin
          n = area + $urandom_range(1, 4);
        end else begin
          // image left open, carried on after the next size change
          n         = $urandom_range(1, 20);
          with_last = 1'b0;
        end
        // big shapes get a short image ended early by the last flag
        if (n > 120) begin
          n = $urandom_range(1, 40);
        end
        case ($urandom_range(0, 3))
          0:       how = PICK_FRESH;
          1:       how = PICK_MIXED;
          default: how = PICK_POOL;
        endcase
        send_image(n, with_last, how);
        random_sent += n;
      end
      finish_phase();
    end

    // nothing outstanding; give any stray result time to show up
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d pixel transactions, %0d results compared", pixels_sent, checked);
    $display("  full-palette misses: %0d, shape errors: %0d", full_hits, shape_hits);
    if (errors == 0 && pending == 0) begin
      $display("[color_palette_indexer_core] OK");
    end else begin
      $display("[color_palette_indexer_core] ERROR");
    end
    $finish;
  end

endmodule
